### src/prq_pkg.sv
// shared types and constants for the priority ready queue
// no dependencies; imported by every other file of the block except prq_ifs.sv
`default_nettype none

package prq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W        = 8;
	localparam int PRI_W       = 8;

	localparam logic ACT_ENQ = 1'b0;
	localparam logic ACT_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0]  task_id;
		logic [PRI_W-1:0] pri;
	} entry_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t entry;
	} cell_cmd_t;

endpackage

`default_nettype wire

### src/prq_ifs.sv
// valid/ready channel interfaces for the request and response words
// depends on nothing; used by the top level of the priority ready queue
`default_nettype none

interface prq_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] task_id;
	logic [7:0] priority_req;

	modport source (output valid, action, task_id, priority_req, input ready);
	modport sink (input valid, action, task_id, priority_req, output ready);
endinterface

interface prq_rsp_if;
	logic       valid;
	logic       ready;
	logic       got_task;
	logic [7:0] out_task_id;
	logic [7:0] out_priority;
	logic [1:0] status;

	modport source (output valid, got_task, out_task_id, out_priority, status, input ready);
	modport sink (input valid, got_task, out_task_id, out_priority, status, output ready);
endinterface

`default_nettype wire

### src/priority_ready_queue_top.sv
// result words are registered: valid the cycle after the request is accepted
// throughput: one request word per cycle unless the response side stalls;
//   every cell compares against the new entry in parallel
// a request is taken whenever the response register is empty or being drained
// reset clears the occupancy count and the response valid; entry contents are
//   not cleared, only slots below the count are ever read
`default_nettype none

module priority_ready_queue_top (
	input  wire          clk,
	input  wire          arst_n,
	prq_req_if.sink      req,
	prq_rsp_if.source    rsp
);
	import prq_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	logic             got_task_q;
	entry_t           out_entry_q;
	status_t          status_q;

	logic             req_fire;
	logic             q_empty;
	logic             q_full;
	cell_cmd_t        cmd;

	entry_t           cell_entry [QUEUE_DEPTH];
	logic             cell_keep  [QUEUE_DEPTH];

	// accept when no result is waiting, or the waiting one leaves this cycle
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_fire  = req.valid && req.ready;

	assign q_empty = (count_q == '0);
	assign q_full  = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		cmd.enq           = req_fire && (req.action == ACT_ENQ) && !q_full;
		cmd.deq           = req_fire && (req.action == ACT_DEQ) && !q_empty;
		cmd.entry.task_id = req.task_id;
		cmd.entry.pri     = req.priority_req;
	end

	// chain of cells, head at index 0; a cell shifts right on enqueue and
	// left on dequeue, the new word lands after the last cell that keeps
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   left_keep;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_keep  = 1'b1;
			assign left_entry = cmd.entry;
		end else begin : g_body
			assign left_keep  = cell_keep[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		prq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.valid       (count_q > CNT_W'(i)),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.enq) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.deq) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// response register: valid is control, the rest is payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			got_task_q  <= cmd.deq;
			out_entry_q <= cmd.deq ? cell_entry[0] : '0;
			if (req.action == ACT_DEQ) begin
				status_q <= q_empty ? ST_EMPTY : ST_OK;
			end else begin
				status_q <= q_full ? ST_FULL : ST_OK;
			end
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.got_task     = got_task_q;
	assign rsp.out_task_id  = out_entry_q.task_id;
	assign rsp.out_priority = out_entry_q.pri;
	assign rsp.status       = status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy above depth");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_entry[0].pri <= cell_entry[1].pri)
		else $error("head entries out of order");

	a_deq_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |=> rsp.valid && rsp.got_task
			&& rsp.out_priority == $past(cell_entry[0].pri))
		else $error("dequeue did not return the head");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("enqueue did not grow the queue");

	a_got_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.got_task |-> rsp.status == ST_OK)
		else $error("returned task with error status");
`endif

endmodule

`default_nettype wire

### src/prq_cell.sv
// one cell of the sorted shift chain: holds one entry, compares and shifts
// depends on prq_pkg
`default_nettype none

module prq_cell (
	input  wire                 clk,
	input  prq_pkg::cell_cmd_t  cmd,
	input  wire                 valid,
	input  wire                 left_keep,
	input  prq_pkg::entry_t     left_entry,
	input  prq_pkg::entry_t     right_entry,
	output prq_pkg::entry_t     entry,
	output logic                keep
);
	import prq_pkg::*;

	entry_t entry_q;

	// entry stays put when it is not less urgent than the new one
	always_comb begin
		keep = valid && (entry_q.pri <= cmd.entry.pri);
	end

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.entry : left_entry;
			end
		end else if (cmd.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

### sim/tb_priority_ready_queue_top.sv
// testbench for priority_ready_queue_top: random request words and a shadow sorted queue
// depends on src/prq_pkg.sv, src/prq_ifs.sv and src/priority_ready_queue_top.sv
`default_nettype none

import prq_pkg::*;

// shadow copy of the ready queue plus the response words it still owes
class ready_queue_shadow;
	typedef struct packed {
		logic             got_task;
		logic [ID_W-1:0]  task_id;
		logic [PRI_W-1:0] pri;
		status_t          status;
	} rsp_word_t;

	entry_t           slots[QUEUE_DEPTH];
	logic [CNT_W-1:0] fill;
	rsp_word_t        owed_rsp[$];
	int               errors;

	function new();
		fill   = '0;
		errors = 0;
	endfunction

	// apply one accepted request word and queue the response it must cause
	function void note_request(logic act, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
		rsp_word_t w;
		int        i;
		int        pos;
		w.got_task = 1'b0;
		w.task_id  = '0;
		w.pri      = '0;
		w.status   = ST_OK;
		if (act == ACT_DEQ) begin
			if (fill == 0) begin
				w.status = ST_EMPTY;
			end else begin
				w.got_task = 1'b1;
				w.task_id  = slots[0].task_id;
				w.pri      = slots[0].pri;
				for (i = 1; i < fill; i++)
					slots[i-1] = slots[i];
				fill = fill - 1'b1;
			end
		end else if (fill == QUEUE_DEPTH) begin
			w.status = ST_FULL;
		end else begin
			// new entry goes ahead of the first strictly larger priority number
			pos = int'(fill);
			for (i = int'(fill) - 1; i >= 0; i--)
				if (slots[i].pri > pri)
					pos = i;
			for (i = int'(fill); i > pos; i--)
				slots[i] = slots[i-1];
			slots[pos].task_id = id;
			slots[pos].pri     = pri;
			fill = fill + 1'b1;
		end
		owed_rsp.push_back(w);
	endfunction

	function void check_response(logic got, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri,
			logic [1:0] st);
		rsp_word_t w;
		if (owed_rsp.size() == 0) begin
			$error("response word with no request pending");
			errors++;
			return;
		end
		w = owed_rsp.pop_front();
		if (got !== w.got_task) begin
			$error("got_task: expected %0d, actual %0d", w.got_task, got);
			errors++;
		end
		if (id !== w.task_id) begin
			$error("out_task_id: expected %0d, actual %0d", w.task_id, id);
			errors++;
		end
		if (pri !== w.pri) begin
			$error("out_priority: expected %0d, actual %0d", w.pri, pri);
			errors++;
		end
		if (st !== w.status) begin
			$error("status: expected %0d, actual %0d", w.status, st);
			errors++;
		end
	endfunction

	function int owed_count();
		return owed_rsp.size();
	endfunction
endclass

module tb_priority_ready_queue_top;

	localparam int RANDOM_WORDS = 480;
	localparam int HOLD_AT      = 150;  // response count at which the long hold-off starts
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_LIMIT  = 1000;

	typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_style_t;

	logic clk = 1'b0;
	logic arst_n;

	prq_req_if req_if ();
	prq_rsp_if rsp_if ();

	priority_ready_queue_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	ready_queue_shadow board = new();
	int                rsp_seen = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// idle gap before the next word; no gap throughout a steady stretch
	function automatic int pick_gap(bit steady);
		return steady ? 0 : $urandom_range(0, 3);
	endfunction

	// offer one request word and hold it until the block takes it
	task automatic send_word(input logic act, input logic [ID_W-1:0] id,
			input logic [PRI_W-1:0] pri, input int gap);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.action       <= act;
		req_if.task_id      <= id;
		req_if.priority_req <= pri;
		// values read right at the edge are the ones the block sampled
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		board.note_request(act, id, pri);
	endtask

	// response side: random stalls, stall-free stretches and one long hold-off
	initial begin : rsp_drain
		int  gap;
		bit  steady;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			steady = ((rsp_seen / 40) % 3) == 2;
			gap    = pick_gap(steady);
			// long hold-off so the response register stays full and requests back up
			if (rsp_seen == HOLD_AT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
			board.check_response(rsp_if.got_task, rsp_if.out_task_id, rsp_if.out_priority,
				rsp_if.status);
			rsp_seen++;
		end
	end

	// ends the run if no word moves on either side for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("tb_priority_ready_queue_top failed");
		$finish;
	end

	initial begin : stimulus
		int               k;
		int               sent;
		int               run_len;
		int               enq_pct;
		bit               steady;
		bit               narrow;
		run_style_t       style;
		logic             act;
		logic [PRI_W-1:0] pri;

		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.action       = ACT_ENQ;
		req_if.task_id      = '0;
		req_if.priority_req = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// dequeue from an empty queue
		send_word(ACT_DEQ, 8'hFF, 8'hFF, 0);

		// fill to the brim: a run of equal priorities for first-in first-out ties,
		// then both priority extremes, alternating bit patterns and random values
		for (k = 0; k < QUEUE_DEPTH; k++) begin
			case (k)
				0, 1, 2, 3: pri = 8'h80;
				4:          pri = 8'hFF;
				5:          pri = 8'h00;
				6:          pri = 8'h55;
				7:          pri = 8'hAA;
				default:    pri = 8'($urandom);
			endcase
			send_word(ACT_ENQ, 8'(k * 17), pri, pick_gap(k < 8));
		end

		// enqueue when full is dropped even though it holds the most urgent priority value
		send_word(ACT_ENQ, 8'hFF, 8'h00, 0);

		// take a few heads off; ignored payload bits still move
		for (k = 0; k < 4; k++)
			send_word(ACT_DEQ, 8'($urandom), 8'($urandom), pick_gap(1'b0));

		// random runs that push the queue toward full, toward empty, or hover
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			run_len = $urandom_range(20, 60);
			style   = run_style_t'($urandom_range(0, 2));
			steady  = ($urandom_range(0, 3) == 0);
			narrow  = ($urandom_range(0, 1) == 1);
			case (style)
				RUN_FILL:  enq_pct = 75;
				RUN_DRAIN: enq_pct = 25;
				default:   enq_pct = 50;
			endcase
			repeat (run_len) begin
				act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQ : ACT_DEQ;
				// few priority levels make ties common
				pri = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
				send_word(act, 8'($urandom), pri, pick_gap(steady));
				sent++;
			end
		end
		req_if.valid <= 1'b0;

		while (board.owed_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0)
			$display("tb_priority_ready_queue_top passed");
		else
			$display("tb_priority_ready_queue_top failed");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
src/prq_pkg.sv
src/prq_ifs.sv
src/prq_cell.sv
src/priority_ready_queue_top.sv
sim/tb_priority_ready_queue_top.sv
